// ===== rtl/frb_pkg.sv =====
// shared types, codes and helper functions of the frame response builder
package frb_pkg;

	// frame geometry: up to 25 body bytes followed by one crc byte
	localparam int FRAME_BYTES = 25;
	localparam int FRAME_W     = FRAME_BYTES * 8;
	localparam int LEN_W       = 5;
	localparam int TAIL_BYTES  = 9;
	localparam int ADDR_W      = 56;
	localparam int TIME_W      = 48;
	localparam int CRC_FIRST   = 2;

	// default depth of the job queue between front and back
	localparam int DEFAULT_QUEUE_DEPTH = 2;

	// request kinds on the func field
	localparam logic [1:0] FUNC_RX      = 2'd0;
	localparam logic [1:0] FUNC_STAT    = 2'd1;
	localparam logic [1:0] FUNC_STAT_EE = 2'd2;
	localparam logic [1:0] FUNC_POLL    = 2'd3;

	// command and frame type bytes
	localparam logic [7:0] CMD_REG      = 8'h90;
	localparam logic [7:0] CMD_REG_ALT  = 8'h89;
	localparam logic [7:0] CMD_ACK      = 8'h91;
	localparam logic [7:0] CMD_TIME     = 8'hF3;
	localparam logic [7:0] TYPE_STAT    = 8'h93;
	localparam logic [7:0] TYPE_STAT_EE = 8'hEE;
	localparam logic [7:0] TYPE_POLL    = 8'h88;
	localparam logic [7:0] LEAD_BYTE    = 8'h7E;

	// payload length bytes
	localparam logic [7:0] PLEN_POLL = 8'h01;
	localparam logic [7:0] PLEN_ACK  = 8'h02;
	localparam logic [7:0] PLEN_REG  = 8'h03;
	localparam logic [7:0] PLEN_TIME = 8'h07;

	// total frame lengths including the crc byte
	localparam logic [LEN_W-1:0] LEN_POLL = 5'd20;
	localparam logic [LEN_W-1:0] LEN_STAT = 5'd21;
	localparam logic [LEN_W-1:0] LEN_ACK  = 5'd21;
	localparam logic [LEN_W-1:0] LEN_REG  = 5'd22;
	localparam logic [LEN_W-1:0] LEN_TIME = 5'd26;

	// request frame byte positions
	localparam logic [LEN_W-1:0] POS_LEAD_HI = 5'd0;
	localparam logic [LEN_W-1:0] POS_LEAD_LO = 5'd1;
	localparam int               POS_PEER    = 9;
	localparam logic [LEN_W-1:0] POS_CMD     = 5'd18;
	localparam logic [LEN_W-1:0] POS_MAX     = 5'd31;

	// crc-8, reflected polynomial
	localparam logic [7:0] CRC_POLY = 8'h8C;

	// check code weights per own address byte, first byte first
	localparam logic [3:0] CHECK_WEIGHT [7] = '{4'd3, 4'd6, 4'd0, 4'd9, 4'd7, 4'd4, 4'd10};

	// one frame to send: body bytes first byte in the top bits, plus total length
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [LEN_W-1:0]   len;
	} job_t;

	// fold one byte into the running crc
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/frb_queue.sv =====
// short job queue between the front and the back
module frb_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  frb_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output frb_pkg::job_t head_job
);
	import frb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_FULL);
	assign avail    = (count_q != '0);
	assign head_job = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/frb_front.sv =====
// front: takes input words, tracks the request frame, builds reply jobs
module frb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic [7:0]                    rx_byte,
	input  logic                          rx_last,
	input  logic [frb_pkg::ADDR_W-1:0]    dest_addr,
	input  logic [frb_pkg::ADDR_W-1:0]    source_addr,
	input  logic [7:0]                    status_code,
	input  logic [frb_pkg::TIME_W-1:0]    clock_time,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [frb_pkg::ADDR_W-1:0]    own_mac,
	input  logic                          q_full,
	output logic                          push,
	output frb_pkg::job_t                 push_job
);
	import frb_pkg::*;

	logic [ADDR_W-1:0] own_mac_q;
	logic [LEN_W-1:0]  pos_q;
	logic [15:0]       lead_q;
	logic [ADDR_W-1:0] peer_q;
	logic [7:0]        cmd_q;

	logic [15:0]       lead_n;
	logic [ADDR_W-1:0] peer_n;
	logic [7:0]        cmd_n;
	logic [15:0]       check;
	logic              accept;
	logic              rx_accept;
	logic [15:0]       head;
	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic [TAIL_BYTES*8-1:0] tail;
	logic [LEN_W-1:0]  len;
	logic              has_frame;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign rx_accept = accept && (func == FUNC_RX);

	// receive state after taking the current byte
	always_comb begin
		lead_n = lead_q;
		peer_n = peer_q;
		cmd_n  = cmd_q;
		if (pos_q == POS_LEAD_HI) begin
			peer_n       = '0;
			cmd_n        = '0;
			lead_n[15:8] = rx_byte;
		end else if (pos_q == POS_LEAD_LO) begin
			lead_n[7:0] = rx_byte;
		end else if (pos_q == POS_CMD) begin
			cmd_n = rx_byte;
		end
		for (int i = 0; i < 7; i++) begin
			if (pos_q == LEN_W'(POS_PEER + i)) begin
				peer_n[(6-i)*8 +: 8] = rx_byte;
			end
		end
	end

	// weighted check code over own address bytes taken as signed
	always_comb begin
		logic [7:0] b;
		check = '0;
		for (int i = 0; i < 7; i++) begin
			b     = own_mac_q[(6-i)*8 +: 8];
			check = check + ({{8{b[7]}}, b} * {12'd0, CHECK_WEIGHT[i]});
		end
	end

	// classify and lay out the reply frame
	always_comb begin
		head      = {LEAD_BYTE, LEAD_BYTE};
		addr_a    = '0;
		addr_b    = source_addr;
		tail      = '0;
		len       = LEN_STAT;
		has_frame = 1'b1;
		case (func)
			FUNC_RX: begin
				head   = lead_n;
				addr_a = peer_n;
				addr_b = own_mac_q;
				case (cmd_n)
					CMD_ACK: begin
						tail = {8'h00, PLEN_ACK, CMD_ACK, 8'h00, 40'h0};
						len  = LEN_ACK;
					end
					CMD_TIME: begin
						tail = {8'h00, PLEN_TIME, CMD_TIME, clock_time};
						len  = LEN_TIME;
					end
					CMD_REG, CMD_REG_ALT: begin
						tail = {8'h00, PLEN_REG, CMD_REG, check, 32'h0};
						len  = LEN_REG;
					end
					default: begin
						has_frame = 1'b0;
					end
				endcase
			end
			FUNC_STAT: begin
				tail = {8'h00, PLEN_ACK, TYPE_STAT, status_code, 40'h0};
			end
			FUNC_STAT_EE: begin
				tail = {8'h00, PLEN_ACK, TYPE_STAT_EE, status_code, 40'h0};
			end
			FUNC_POLL: begin
				addr_a = dest_addr;
				tail   = {8'h00, PLEN_POLL, TYPE_POLL, 48'h0};
				len    = LEN_POLL;
			end
			default: begin
				has_frame = 1'b0;
			end
		endcase
	end

	assign push           = accept && has_frame && ((func != FUNC_RX) || rx_last);
	assign push_job.frame = {head, addr_a, addr_b, tail};
	assign push_job.len   = len;

	// own address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_mac_q <= own_mac;
		end
	end

	// request frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			lead_q <= '0;
			peer_q <= '0;
			cmd_q  <= '0;
		end else if (rx_accept) begin
			lead_q <= lead_n;
			peer_q <= peer_n;
			cmd_q  <= cmd_n;
			if (rx_last) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/frb_back.sv =====
// back: sends one queued frame a byte per word and appends the crc
module frb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_avail,
	input  frb_pkg::job_t q_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    tx_byte,
	output logic          tx_last
);
	import frb_pkg::*;

	logic [FRAME_W-1:0] sr_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   idx_q;
	logic [7:0]         crc_q;
	logic               busy_q;
	logic               out_accept;

	assign out_valid  = busy_q;
	assign tx_last    = busy_q && (idx_q == len_q - 1'b1);
	assign tx_byte    = tx_last ? crc_q : sr_q[FRAME_W-1 -: 8];
	assign out_accept = out_valid && out_ready;
	assign pop        = q_avail && (!busy_q || (out_accept && tx_last));

	// frame shifter and crc
	always_ff @(posedge clk) begin
		if (pop) begin
			sr_q  <= q_job.frame;
			crc_q <= '0;
		end else if (out_accept && !tx_last) begin
			sr_q <= {sr_q[FRAME_W-9:0], 8'h00};
			if (idx_q >= LEN_W'(CRC_FIRST)) begin
				crc_q <= crc8_byte(crc_q, tx_byte);
			end
		end
	end

	// send control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			len_q  <= '0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			len_q  <= q_job.len;
			idx_q  <= '0;
		end else if (out_accept) begin
			if (tx_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// position never runs past the frame end
	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < len_q))
		else $error("send position past frame end");

	// a new frame is loaded only when the previous one is done
	a_pop_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy_q || (out_ready && tx_last)))
		else $error("frame loaded over one in flight");

	// the last word with nothing queued leaves the output empty
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && tx_last && !q_avail) |=> !out_valid)
		else $error("output still valid after final word");

endmodule

// ===== rtl/frame_response_builder_core.sv =====
// top level of the frame response builder: front, job queue and back
//
// channel | handshake            | words
// --------+----------------------+--------------------------------------------
// in      | in_valid / in_ready  | func, rx_byte, rx_last, addresses, status, time
// cfg     | cfg_valid / cfg_ready| own_mac, always ready
// out     | out_valid / out_ready| tx_byte, tx_last
//
// input words are taken one per cycle while the job queue has room; a request
// byte that completes no reply is taken but pushes no job.
// a reply frame of 20 to 26 bytes leaves one byte per cycle while out_ready is high, the crc last;
// the back loads the next queued frame in the cycle the previous crc is taken.
// the front stalls only when the job queue is full; the back stalls on out_ready.
// reset clears the receive state, own_mac, the queue and the send control.
module frame_response_builder_core #(
	parameter int QUEUE_DEPTH = frb_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic [7:0]                    rx_byte,
	input  logic                          rx_last,
	input  logic [frb_pkg::ADDR_W-1:0]    dest_addr,
	input  logic [frb_pkg::ADDR_W-1:0]    source_addr,
	input  logic [7:0]                    status_code,
	input  logic [frb_pkg::TIME_W-1:0]    clock_time,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [frb_pkg::ADDR_W-1:0]    own_mac,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    tx_byte,
	output logic                          tx_last
);
	import frb_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_avail;
	job_t push_job;
	job_t head_job;

	// request tracking and job build
	frb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.rx_byte     (rx_byte),
		.rx_last     (rx_last),
		.dest_addr   (dest_addr),
		.source_addr (source_addr),
		.status_code (status_code),
		.clock_time  (clock_time),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.own_mac     (own_mac),
		.q_full      (q_full),
		.push        (q_push),
		.push_job    (push_job)
	);

	// job queue
	frb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head_job (head_job)
	);

	// byte sender with crc
	frb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (q_avail),
		.q_job     (head_job),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.tx_last   (tx_last)
	);

endmodule

// ===== dv/frb_reply_checker.sv =====
// reply checker: predicts the response bytes of the frame response builder and compares them
module frb_reply_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [7:0]                 rx_byte,
	input  logic                       rx_last,
	input  logic [frb_pkg::ADDR_W-1:0] dest_addr,
	input  logic [frb_pkg::ADDR_W-1:0] source_addr,
	input  logic [7:0]                 status_code,
	input  logic [frb_pkg::TIME_W-1:0] clock_time,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [frb_pkg::ADDR_W-1:0] own_mac,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [7:0]                 tx_byte,
	input  logic                       tx_last,
	output int                         mismatch_count,
	output int                         reply_backlog
);
	timeunit 1ns;
	timeprecision 1ps;
	import frb_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} reply_word_t;

	// expected reply words, oldest first
	reply_word_t reply_bytes_q [$];

	// shadow of the block's register and receive state
	logic [ADDR_W-1:0] mac_shadow;
	logic [4:0]        rx_pos;
	logic [15:0]       rx_lead;
	logic [ADDR_W-1:0] rx_peer;
	logic [7:0]        rx_cmd;

	// frame under construction
	logic [7:0] frame_buf [26];

	task automatic clear_frame();
		for (int i = 0; i < 26; i++) begin
			frame_buf[i] = 8'h00;
		end
	endtask

	task automatic place_addr(input int at, input logic [ADDR_W-1:0] addr);
		for (int i = 0; i < 7; i++) begin
			frame_buf[at + i] = addr[8 * (6 - i) +: 8];
		end
	endtask

	// append the crc over bytes 2 onward and queue the whole frame
	task automatic queue_frame(input logic [LEN_W-1:0] len);
		logic [7:0]  crc;
		reply_word_t w;
		crc = 8'h00;
		for (int i = CRC_FIRST; i < len - 1; i++) begin
			for (int b = 0; b < 8; b++) begin
				if (crc[0] ^ frame_buf[i][b])
					crc = {1'b0, crc[7:1]} ^ CRC_POLY;
				else
					crc = {1'b0, crc[7:1]};
			end
		end
		frame_buf[len - 1] = crc;
		for (int i = 0; i < len; i++) begin
			w.data = frame_buf[i];
			w.last = (i == len - 1);
			reply_bytes_q.push_back(w);
		end
	endtask

	// weighted sum of the own address bytes, each byte signed
	function automatic logic [15:0] mac_check_code(input logic [ADDR_W-1:0] mac);
		int sum;
		sum = 0;
		for (int i = 0; i < 7; i++) begin
			sum += int'($signed(mac[8 * (6 - i) +: 8])) * int'(CHECK_WEIGHT[i]);
		end
		return sum[15:0];
	endfunction

	// work out the reply caused by one accepted input word
	task automatic predict_reply();
		logic [15:0] code;
		clear_frame();
		if (func != FUNC_RX) begin
			frame_buf[0] = LEAD_BYTE;
			frame_buf[1] = LEAD_BYTE;
			if (func == FUNC_POLL) begin
				place_addr(2, dest_addr);
				place_addr(9, source_addr);
				frame_buf[17] = PLEN_POLL;
				frame_buf[18] = TYPE_POLL;
				queue_frame(LEN_POLL);
			end else begin
				place_addr(9, source_addr);
				frame_buf[17] = PLEN_ACK;
				frame_buf[18] = (func == FUNC_STAT) ? TYPE_STAT : TYPE_STAT_EE;
				frame_buf[19] = status_code;
				queue_frame(LEN_STAT);
			end
			return;
		end

		// capture the request byte at its position
		if (rx_pos == POS_LEAD_HI) begin
			rx_peer = '0;
			rx_cmd  = 8'h00;
			rx_lead[15:8] = rx_byte;
		end else if (rx_pos == POS_LEAD_LO) begin
			rx_lead[7:0] = rx_byte;
		end else if (rx_pos >= POS_PEER && rx_pos <= POS_PEER + 6) begin
			rx_peer[8 * (POS_PEER + 6 - rx_pos) +: 8] = rx_byte;
		end else if (rx_pos == POS_CMD) begin
			rx_cmd = rx_byte;
		end
		if (rx_pos != POS_MAX)
			rx_pos = rx_pos + 5'd1;

		if (!rx_last)
			return;
		rx_pos = '0;
		if (rx_cmd != CMD_REG && rx_cmd != CMD_REG_ALT && rx_cmd != CMD_ACK &&
				rx_cmd != CMD_TIME)
			return;

		frame_buf[0] = rx_lead[15:8];
		frame_buf[1] = rx_lead[7:0];
		place_addr(2, rx_peer);
		place_addr(9, mac_shadow);
		if (rx_cmd == CMD_ACK) begin
			frame_buf[17] = PLEN_ACK;
			frame_buf[18] = CMD_ACK;
			queue_frame(LEN_ACK);
		end else if (rx_cmd == CMD_TIME) begin
			frame_buf[17] = PLEN_TIME;
			frame_buf[18] = CMD_TIME;
			for (int i = 0; i < 6; i++) begin
				frame_buf[19 + i] = clock_time[8 * (5 - i) +: 8];
			end
			queue_frame(LEN_TIME);
		end else begin
			code = mac_check_code(mac_shadow);
			frame_buf[17] = PLEN_REG;
			frame_buf[18] = CMD_REG;
			frame_buf[19] = code[15:8];
			frame_buf[20] = code[7:0];
			queue_frame(LEN_REG);
		end
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		reply_word_t want;
		if (!arst_n) begin
			reply_bytes_q.delete();
			mac_shadow     = '0;
			rx_pos         = '0;
			rx_lead        = '0;
			rx_peer        = '0;
			rx_cmd         = '0;
			mismatch_count = 0;
			reply_backlog  = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				mac_shadow = own_mac;
			if (in_valid && in_ready)
				predict_reply();
			if (out_valid && out_ready) begin
				if (reply_bytes_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected word tx_byte=%h tx_last=%b",
							$realtime, tx_byte, tx_last);
				end else begin
					want = reply_bytes_q.pop_front();
					if (tx_byte !== want.data || tx_last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch expected %h/%b actual %h/%b",
								$realtime, want.data, want.last, tx_byte, tx_last);
					end
				end
			end
			reply_backlog = reply_bytes_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// testbench top: drives request words and own address writes into the frame response builder
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import frb_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        func = FUNC_RX;
	logic [7:0]        rx_byte = '0;
	logic              rx_last = 1'b0;
	logic [ADDR_W-1:0] dest_addr = '0;
	logic [ADDR_W-1:0] source_addr = '0;
	logic [7:0]        status_code = '0;
	logic [TIME_W-1:0] clock_time = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ADDR_W-1:0] own_mac = '0;
	logic              out_valid;
	logic              out_ready = 1'b1;
	logic [7:0]        tx_byte;
	logic              tx_last;

	int mismatch_count;
	int reply_backlog;
	int words_sent = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	frame_response_builder_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.rx_byte    (rx_byte),
		.rx_last    (rx_last),
		.dest_addr  (dest_addr),
		.source_addr(source_addr),
		.status_code(status_code),
		.clock_time (clock_time),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.own_mac    (own_mac),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_byte    (tx_byte),
		.tx_last    (tx_last)
	);

	frb_reply_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.rx_byte       (rx_byte),
		.rx_last       (rx_last),
		.dest_addr     (dest_addr),
		.source_addr   (source_addr),
		.status_code   (status_code),
		.clock_time    (clock_time),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.own_mac       (own_mac),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_byte       (tx_byte),
		.tx_last       (tx_last),
		.mismatch_count(mismatch_count),
		.reply_backlog (reply_backlog)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver side stalls in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			out_ready = 1'b0;
			stall_left = $urandom_range(1, 17) - 1;
		end else begin
			out_ready = 1'b1;
		end
	end

	// random address, biased toward the extremes
	function automatic logic [ADDR_W-1:0] rand_addr();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return ADDR_W'({$urandom, $urandom});
		endcase
	endfunction

	// offer one input word and hold it until accepted
	task automatic send_word(input logic [1:0] f, input logic [7:0] b, input logic l,
			input logic [ADDR_W-1:0] d, input logic [ADDR_W-1:0] s,
			input logic [7:0] st, input logic [TIME_W-1:0] t);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    = 1'b1;
		func        = f;
		rx_byte     = b;
		rx_last     = l;
		dest_addr   = d;
		source_addr = s;
		status_code = st;
		clock_time  = t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	// frame command with junk in the request fields
	task automatic send_frame_cmd(input logic [1:0] f, input logic [ADDR_W-1:0] d,
			input logic [ADDR_W-1:0] s, input logic [7:0] st);
		send_word(f, 8'($urandom), 1'($urandom), d, s, st, TIME_W'({$urandom, $urandom}));
	endtask

	// request frame of len bytes; mix drops frame commands in between
	task automatic send_request(input logic [15:0] lead, input logic [ADDR_W-1:0] peer,
			input logic [7:0] cmd, input int len, input logic [TIME_W-1:0] t, input bit mix);
		logic [7:0] b;
		for (int p = 0; p < len; p++) begin
			b = 8'($urandom);
			if (p == POS_LEAD_HI)
				b = lead[15:8];
			else if (p == POS_LEAD_LO)
				b = lead[7:0];
			else if (p >= POS_PEER && p <= POS_PEER + 6)
				b = peer[8 * (POS_PEER + 6 - p) +: 8];
			else if (p == POS_CMD)
				b = cmd;
			if (mix && $urandom_range(0, 9) == 0)
				send_frame_cmd(2'($urandom_range(1, 3)), rand_addr(), rand_addr(),
					8'($urandom));
			send_word(FUNC_RX, b, p == len - 1, rand_addr(), rand_addr(), 8'($urandom), t);
		end
	endtask

	// let every reply drain, then write the own address
	task automatic write_mac(input logic [ADDR_W-1:0] value);
		@(negedge clk);
		in_valid = 1'b0;
		while (reply_backlog != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid = 1'b1;
		own_mac   = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] pick_cmd();
		case ($urandom_range(0, 4))
			0: return CMD_REG;
			1: return CMD_REG_ALT;
			2: return CMD_ACK;
			3: return CMD_TIME;
			default: return 8'($urandom);
		endcase
	endfunction

	// stimulus and verdict
	initial begin
		int start;
		int pick;
		logic [ADDR_W-1:0] mac_val;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed part
		write_mac('1);
		send_frame_cmd(FUNC_STAT, '0, '0, 8'h00);
		send_frame_cmd(FUNC_STAT_EE, '1, '1, 8'hFF);
		send_frame_cmd(FUNC_POLL, '0, '0, 8'h00);
		send_frame_cmd(FUNC_POLL, '1, '0, 8'hFF);
		send_request(16'h7E7E, '1, CMD_REG, 19, '0, 1'b0);
		send_request(16'hFFFF, '0, CMD_REG_ALT, 20, '1, 1'b0);
		send_request(16'h0000, ADDR_W'({$urandom, $urandom}), CMD_ACK, 19, '0, 1'b0);
		send_request(16'h1234, ADDR_W'({$urandom, $urandom}), CMD_TIME, 19, '1, 1'b0);
		send_request(16'h5A5A, '1, 8'h00, 19, '0, 1'b0);
		// first byte last, then a frame ending before the command byte
		send_request(16'hAAAA, '1, CMD_ACK, 1, '0, 1'b0);
		send_request(16'h5555, '1, CMD_ACK, 18, '0, 1'b0);
		// long frame saturates the position count
		send_request(16'hC3C3, ADDR_W'({$urandom, $urandom}), CMD_TIME, 40,
			TIME_W'({$urandom, $urandom}), 1'b0);
		write_mac(56'h80_80_80_80_80_80_80);
		send_request(16'h7E7E, ADDR_W'({$urandom, $urandom}), CMD_REG, 19, '0, 1'b1);
		write_mac('0);
		send_request(16'h7E7E, ADDR_W'({$urandom, $urandom}), CMD_REG_ALT, 19, '0, 1'b1);

		// random part in phases, the last one without idling
		start = words_sent;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: mac_val = 56'h80_7F_80_7F_80_7F_80;
				3: mac_val = 56'h7F_7F_7F_7F_7F_7F_7F;
				default: mac_val = ADDR_W'({$urandom, $urandom});
			endcase
			write_mac(mac_val);
			idle_on = (phase < 4);
			while (words_sent - start < (phase + 1) * 38) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					send_request(16'($urandom), rand_addr(), pick_cmd(),
						19 + int'($urandom_range(0, 5)),
						TIME_W'({$urandom, $urandom}), $urandom_range(0, 3) == 0);
				else if (pick < 78)
					send_frame_cmd(2'($urandom_range(1, 3)), rand_addr(), rand_addr(),
						8'($urandom));
				else if (pick < 92)
					send_request(16'($urandom), rand_addr(), pick_cmd(),
						int'($urandom_range(1, 18)), TIME_W'({$urandom, $urandom}), 1'b1);
				else
					send_request(16'($urandom), rand_addr(), pick_cmd(),
						int'($urandom_range(19, 40)), TIME_W'({$urandom, $urandom}), 1'b0);
			end
		end

		// drain and give the verdict
		@(negedge clk);
		in_valid = 1'b0;
		while (reply_backlog != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && reply_backlog == 0)
			$display("frame_response_builder_core regression: pass");
		else
			$display("frame_response_builder_core regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("frame_response_builder_core regression: fail");
		$finish;
	end

endmodule
